@@ rtl/core/gmcs_pkg.sv @@
// Package for the gripper mode command sequencer.
// Holds the request and result structs, the mode enum and the frame byte codes.
// Depends on nothing.
package gmcs_pkg;

  typedef enum logic [1:0] {
    MODE_INIT   = 2'd0,
    MODE_TEST   = 2'd1,
    MODE_RUN    = 2'd2,
    MODE_PICKED = 2'd3
  } mode_e;

  localparam logic [7:0] GRP_TEST       = 8'h01;
  localparam logic [7:0] GRP_GRIP       = 8'h10;
  localparam logic [7:0] ACT_TEST_ENTER = 8'h11;
  localparam logic [7:0] ACT_TEST_QUIT  = 8'h00;
  localparam logic [7:0] ACT_RUN        = 8'h13;
  localparam logic [7:0] ACT_IDLE       = 8'h8C;
  localparam logic [7:0] ACT_PICK       = 8'h5A;
  localparam logic [7:0] ACT_PLACE      = 8'h69;

  localparam logic [15:0] SHORT_GAP_RESET = 16'd10;
  localparam logic [15:0] LONG_GAP_RESET  = 16'd2000;

  localparam logic CFG_SHORT_GAP = 1'b0;
  localparam logic CFG_LONG_GAP  = 1'b1;

  typedef struct packed {
    logic [3:0]  request_bits;
    logic [31:0] now_ms;
  } in_req_t;

  typedef struct packed {
    logic       frame_sent;
    logic [7:0] frame_byte0;
    logic [7:0] frame_byte1;
    logic [1:0] mode_after;
    logic       request_cleared;
  } out_res_t;

  typedef struct packed {
    logic     send;
    mode_e    next_mode;
    logic     hold_upd;
    logic     hold_val;
    out_res_t res;
  } dec_t;

endpackage

@@ rtl/core/gmcs_decide.sv @@
// Per-request decision logic of the gripper mode command sequencer.
// Picks the frame by mode and priority and checks the send gap.
// Depends on gmcs_pkg.
module gmcs_decide import gmcs_pkg::*; (
  input  in_req_t     req_i,
  input  mode_e       mode_i,
  input  logic        holding_i,
  input  logic [31:0] last_send_i,
  input  logic [15:0] short_gap_i,
  input  logic [15:0] long_gap_i,
  output dec_t        dec_o
);

  logic        t, r, p, pl;
  logic        want, long_kind, clr, hold_upd, hold_val;
  logic [7:0]  b0, b1;
  mode_e       nxt;
  logic [31:0] elapsed;
  logic [15:0] gap;
  logic        gap_ok;

  assign t  = req_i.request_bits[0];
  assign r  = req_i.request_bits[1];
  assign p  = req_i.request_bits[2];
  assign pl = req_i.request_bits[3];

  always_comb begin
    want      = 1'b0;
    long_kind = 1'b0;
    clr       = 1'b0;
    hold_upd  = 1'b0;
    hold_val  = 1'b0;
    b0        = 8'h00;
    b1        = 8'h00;
    nxt       = mode_i;
    case (mode_i)
      MODE_INIT: begin
        if (t) begin
          want = 1'b1; b0 = GRP_TEST; b1 = ACT_TEST_ENTER; nxt = MODE_TEST;
        end else if (r) begin
          want = 1'b1; b0 = GRP_GRIP; b1 = ACT_RUN; nxt = MODE_RUN;
        end
      end
      MODE_TEST: begin
        if (!t) begin
          want = 1'b1; b0 = GRP_TEST; b1 = ACT_TEST_QUIT; nxt = MODE_INIT;
        end else if (r) begin
          want = 1'b1; b0 = GRP_TEST; b1 = ACT_TEST_QUIT; nxt = MODE_RUN;
        end
      end
      MODE_RUN: begin
        if (!r) begin
          want = 1'b1; b0 = GRP_GRIP; b1 = ACT_IDLE; nxt = MODE_INIT;
        end else if (t) begin
          want = 1'b1; b0 = GRP_TEST; b1 = ACT_TEST_ENTER; nxt = MODE_TEST;
        end else if (p) begin
          want = 1'b1; long_kind = 1'b1; b0 = GRP_GRIP; b1 = ACT_PICK;
          nxt = MODE_PICKED; clr = 1'b1; hold_upd = 1'b1; hold_val = 1'b1;
        end else if (pl && holding_i) begin
          want = 1'b1; long_kind = 1'b1; b0 = GRP_GRIP; b1 = ACT_PLACE;
          nxt = MODE_RUN; clr = 1'b1; hold_upd = 1'b1; hold_val = 1'b0;
        end
      end
      MODE_PICKED: begin
        if (!r) begin
          want = 1'b1; b0 = GRP_GRIP; b1 = ACT_IDLE; nxt = MODE_INIT;
        end else if (t) begin
          want = 1'b1; b0 = GRP_TEST; b1 = ACT_TEST_ENTER; nxt = MODE_TEST;
        end else if (pl) begin
          want = 1'b1; long_kind = 1'b1; b0 = GRP_GRIP; b1 = ACT_PLACE;
          nxt = MODE_RUN; clr = 1'b1; hold_upd = 1'b1; hold_val = 1'b0;
        end
      end
      default: begin
        want = 1'b0;
      end
    endcase
  end

  assign elapsed = req_i.now_ms - last_send_i;
  assign gap     = long_kind ? long_gap_i : short_gap_i;
  assign gap_ok  = (elapsed >= {16'd0, gap});

  always_comb begin
    dec_o.send                = want && gap_ok;
    dec_o.next_mode           = dec_o.send ? nxt : mode_i;
    dec_o.hold_upd            = dec_o.send && hold_upd;
    dec_o.hold_val            = hold_val;
    dec_o.res.frame_sent      = dec_o.send;
    dec_o.res.frame_byte0     = dec_o.send ? b0 : 8'h00;
    dec_o.res.frame_byte1     = dec_o.send ? b1 : 8'h00;
    dec_o.res.mode_after      = dec_o.next_mode;
    dec_o.res.request_cleared = dec_o.send && clr;
  end

endmodule

@@ rtl/core/gripper_mode_command_sequencer_core.sv @@
// Top level of the gripper mode command sequencer: request and result
// registers, mode state, send time, holding flag and gap registers.
// Depends on gmcs_pkg and gmcs_decide.
//
//   Channel | Direction | Handshake               | Payload
//   --------+-----------+-------------------------+---------------------
//   in      | input     | in_valid_i / in_stall_o | in_data_i (in_req_t)
//   out     | output    | out_valid_o/ out_stall_i| out_data_o (out_res_t)
//   cfg     | input     | cfg_we_i                | cfg_idx_i, cfg_data_i
//
// A request is taken into the input register and decided from there, where the mode,
// send time and holding flag update together with the result register, so one
// request per cycle is sustained while the result register is not stalled.
// Reset puts the mode in init, the send time at zero and the gaps at 10 and
// 2000 ms. While the result register is stalled one request waits in the
// input register, and only then is the input stalled.
module gripper_mode_command_sequencer_core import gmcs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_req_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_res_t    out_data_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  logic        in_vld_q;
  in_req_t     in_q;
  logic        out_vld_q;
  out_res_t    out_q;
  mode_e       mode_q;
  logic [31:0] last_q;
  logic        hold_q;
  logic [15:0] short_q, long_q;
  logic        advance, in_take;
  dec_t        dec;

  gmcs_decide u_decide (
    .req_i       (in_q),
    .mode_i      (mode_q),
    .holding_i   (hold_q),
    .last_send_i (last_q),
    .short_gap_i (short_q),
    .long_gap_i  (long_q),
    .dec_o       (dec)
  );

  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      mode_q    <= MODE_INIT;
      last_q    <= 32'd0;
      hold_q    <= 1'b0;
      short_q   <= SHORT_GAP_RESET;
      long_q    <= LONG_GAP_RESET;
    end else begin
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
        mode_q    <= dec.next_mode;
        if (dec.send) begin
          last_q <= in_q.now_ms;
        end
        if (dec.hold_upd) begin
          hold_q <= dec.hold_val;
        end
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SHORT_GAP: short_q <= cfg_data_i;
          CFG_LONG_GAP:  long_q  <= cfg_data_i;
          default:       short_q <= short_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q <= dec.res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

@@ rtl/core/gmcs_chk.sv @@
// Port-level checker for the gripper mode command sequencer result channel.
// Depends on gmcs_pkg; bound to gripper_mode_command_sequencer_core below.
module gmcs_chk import gmcs_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     out_valid_i,
  input logic     out_stall_i,
  input out_res_t out_data_i
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_stall_i) |=> (out_valid_i && $stable(out_data_i)))
    else $error("Stalled result changed.");

  a_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_data_i.frame_sent) |->
      (out_data_i.frame_byte0 == 8'h00 && out_data_i.frame_byte1 == 8'h00 &&
       !out_data_i.request_cleared))
    else $error("Result without a frame carries frame bytes.");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_data_i.request_cleared) |->
      (out_data_i.frame_sent && out_data_i.frame_byte0 == GRP_GRIP &&
       (out_data_i.frame_byte1 == ACT_PICK || out_data_i.frame_byte1 == ACT_PLACE)))
    else $error("Request cleared without a pick or place frame.");

  a_test_grp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_data_i.frame_sent && out_data_i.frame_byte0 == GRP_TEST) |->
      ((out_data_i.frame_byte1 == ACT_TEST_ENTER &&
        out_data_i.mode_after == MODE_TEST) ||
       (out_data_i.frame_byte1 == ACT_TEST_QUIT &&
        (out_data_i.mode_after == MODE_INIT || out_data_i.mode_after == MODE_RUN))))
    else $error("Test group frame disagrees with the new mode.");

  a_pick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_data_i.frame_sent && out_data_i.frame_byte1 == ACT_PICK) |->
      (out_data_i.mode_after == MODE_PICKED))
    else $error("Pick frame did not enter picked mode.");

endmodule

bind gripper_mode_command_sequencer_core gmcs_chk u_gmcs_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_i  (out_data_o)
);
